>>> hw/rtl/julia_escape_time_unit_assert.svh
// assertion macros for the julia escape-time unit
// expects clk and rst_n in the scope of every use
`ifndef JULIA_ESCAPE_TIME_UNIT_ASSERT_SVH
`define JULIA_ESCAPE_TIME_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JET_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jet assertion failed");

// next-cycle implication, disabled during reset
`define JET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jet assertion failed");

`endif

>>> hw/rtl/jet_pkg.sv
// shared types and constants for the julia escape-time unit
// no dependencies
package jet_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int Z_W         = 32;
    localparam int C_W         = 30;
    localparam int COUNT_W     = 16;
    localparam int PROD_W      = 2 * Z_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_CONST_RE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_IM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

    localparam logic signed [C_W-1:0]   CONST_RE_RESET = 30'sd161061274;
    localparam logic signed [C_W-1:0]   CONST_IM_RESET = -30'sd107374182;
    localparam logic [COUNT_W-1:0]      LIMIT_RESET    = 16'd1000;

    typedef struct packed {
        logic signed [C_W-1:0] const_re;
        logic signed [C_W-1:0] const_im;
        logic [COUNT_W-1:0]    iteration_limit;
    } jet_cfg_t;

endpackage

>>> hw/rtl/jet_cfg.sv
// configuration registers: julia constant and iteration limit
// depends on jet_pkg
module jet_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [jet_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]   cfg_data,
    output jet_pkg::jet_cfg_t                cfg
);

    jet_pkg::jet_cfg_t cfg_reg;
    jet_pkg::jet_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                jet_pkg::CFG_CONST_RE: cfg_next.const_re = $signed(cfg_data[jet_pkg::C_W-1:0]);
                jet_pkg::CFG_CONST_IM: cfg_next.const_im = $signed(cfg_data[jet_pkg::C_W-1:0]);
                jet_pkg::CFG_LIMIT:    cfg_next.iteration_limit = cfg_data[jet_pkg::COUNT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.const_re        <= jet_pkg::CONST_RE_RESET;
            cfg_reg.const_im        <= jet_pkg::CONST_IM_RESET;
            cfg_reg.iteration_limit <= jet_pkg::LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/jet_mul.sv
// shared signed 32x32 multiplier with registered product
// depends on jet_pkg
module jet_mul
(
    input  logic                               clk,
    input  logic signed [jet_pkg::Z_W-1:0]     mul_a,
    input  logic signed [jet_pkg::Z_W-1:0]     mul_b,
    output logic signed [jet_pkg::PROD_W-1:0]  product
);

    logic signed [jet_pkg::PROD_W-1:0] prod_reg;
    logic signed [jet_pkg::PROD_W-1:0] prod_next;

    assign prod_next = jet_pkg::PROD_W'(mul_a) * jet_pkg::PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

>>> hw/rtl/jet_core.sv
// escape-time sequencer: runs re*re, im*im, re*im through one multiplier per step
// depends on jet_pkg, jet_mul and julia_escape_time_unit_assert.svh
`include "julia_escape_time_unit_assert.svh"

module jet_core
#(
    parameter int FRAC_BITS = jet_pkg::FRAC_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  jet_pkg::jet_cfg_t                   cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [jet_pkg::Z_W-1:0]      start_re,
    input  logic signed [jet_pkg::Z_W-1:0]      start_im,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [jet_pkg::COUNT_W-1:0]         escape_count
);

    localparam int Z_W    = jet_pkg::Z_W;
    localparam int C_W    = jet_pkg::C_W;
    localparam int CNT_W  = jet_pkg::COUNT_W;
    localparam int PROD_W = jet_pkg::PROD_W;

    // with a wide fraction the escape threshold exceeds every possible sum
    localparam bit ALWAYS_IN = (2 * FRAC_BITS + 2 >= PROD_W);
    localparam logic [PROD_W-1:0] MAG_LIMIT =
        ALWAYS_IN ? '1 : (PROD_W'(4) << (2 * FRAC_BITS));

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RR   = 5'b00010,
        S_II   = 5'b00100,
        S_RI   = 5'b01000,
        S_TEST = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [Z_W-1:0]      re_reg, re_next;
    logic signed [Z_W-1:0]      im_reg, im_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [PROD_W-1:0]          rr_reg, rr_next;
    logic [PROD_W-1:0]          ii_reg, ii_next;
    logic                       out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]           result_reg, result_next;

    logic signed [Z_W-1:0]      mul_a, mul_b;
    logic signed [PROD_W-1:0]   product;

    logic [PROD_W-1:0]          mag;
    logic                       in_disc;
    logic [CNT_W:0]             count_inc;
    logic                       at_limit;
    logic                       finish;
    logic                       slot_free;
    logic signed [PROD_W-1:0]   sq_diff;
    logic signed [PROD_W-1:0]   sq_shift;
    logic signed [PROD_W-1:0]   cross_shift;
    logic signed [Z_W-1:0]      c_re_ext, c_im_ext;
    logic signed [Z_W-1:0]      new_re, new_im;

    jet_mul u_mul
    (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    // operand select; re*im is the idle default so the cross product holds in S_TEST
    always_comb
    begin
        unique case (state_reg)
            S_RR:
            begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
            S_II:
            begin
                mul_a = im_reg;
                mul_b = im_reg;
            end
            default:
            begin
                mul_a = re_reg;
                mul_b = im_reg;
            end
        endcase
    end

    assign mag       = rr_reg + ii_reg;
    assign in_disc   = ALWAYS_IN || (mag <= MAG_LIMIT);
    assign count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign at_limit  = count_inc >= {1'b0, cfg.iteration_limit};
    assign finish    = !in_disc || at_limit;
    assign slot_free = !out_valid_reg || out_ready;

    assign sq_diff     = $signed(rr_reg) - $signed(ii_reg);
    assign sq_shift    = sq_diff >>> FRAC_BITS;
    assign cross_shift = product >>> (FRAC_BITS - 1);
    assign c_re_ext    = {{(Z_W-C_W){cfg.const_re[C_W-1]}}, cfg.const_re};
    assign c_im_ext    = {{(Z_W-C_W){cfg.const_im[C_W-1]}}, cfg.const_im};
    assign new_re      = sq_shift[Z_W-1:0] + c_re_ext;
    assign new_im      = cross_shift[Z_W-1:0] + c_im_ext;

    always_comb
    begin
        state_next     = state_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        count_next     = count_reg;
        rr_next        = rr_reg;
        ii_next        = ii_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    re_next    = start_re;
                    im_next    = start_im;
                    count_next = '0;
                    state_next = S_RR;
                end
            end
            S_RR:
            begin
                state_next = S_II;
            end
            S_II:
            begin
                rr_next    = product;
                state_next = S_RI;
            end
            S_RI:
            begin
                ii_next    = product;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (finish)
                begin
                    // hold here until the output register can take the result
                    if (slot_free)
                    begin
                        result_next    = in_disc ? count_inc[CNT_W-1:0] : count_reg;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    count_next = count_inc[CNT_W-1:0];
                    re_next    = new_re;
                    im_next    = new_im;
                    state_next = S_RR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg     <= re_next;
        im_reg     <= im_next;
        count_reg  <= count_next;
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        result_reg <= result_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign escape_count = result_reg;

    `JET_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_RR && count_reg == '0)
    `JET_ASSERT_SAME(a_count_below_limit, state_reg != S_IDLE,
                     count_reg == '0 || count_reg < cfg.iteration_limit)
    `JET_ASSERT_SAME(a_result_from_test, $rose(out_valid_reg), $past(state_reg == S_TEST))

endmodule

>>> hw/rtl/julia_escape_time_unit.sv
// julia-set escape-time unit: top level with config registers and iteration core
// depends on jet_pkg, jet_cfg, jet_core
//
//  channel   signals                                   direction
//  in        in_valid, in_ready, start_re, start_im    request in
//  out       out_valid, out_ready, escape_count        request out
//  cfg       cfg_write_en, cfg_index, cfg_data         write only
//
// a point runs t tests; t is its escape count + 1, or the limit (one for a zero limit) if it never escapes
// each test runs three products through the single shared multiplier plus a compare state
// in_ready is high only while the core is idle; a finished result waits in the output register
// a stalled output holds the core in its test state until the result register frees up
// reset sets c to 0.6 - 0.4i and the limit to 1000
module julia_escape_time_unit
#(
    parameter int FRAC_BITS = jet_pkg::FRAC_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [jet_pkg::Z_W-1:0]     start_re,
    input  logic signed [jet_pkg::Z_W-1:0]     start_im,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [jet_pkg::COUNT_W-1:0]        escape_count,
    input  logic                               cfg_write_en,
    input  logic [jet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]     cfg_data
);

    jet_pkg::jet_cfg_t cfg;

    jet_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    jet_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_re     (start_re),
        .start_im     (start_im),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count)
    );

endmodule

>>> dv/testbench.sv
// testbench for julia_escape_time_unit: drives start points, checks escape counts
// holds its own fixed-point predictor of the iteration; depends on jet_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    localparam int          FRAC_BITS        = jet_pkg::FRAC_BITS;
    localparam int          Z_W              = jet_pkg::Z_W;
    localparam int          C_W              = jet_pkg::C_W;
    localparam int          COUNT_W          = jet_pkg::COUNT_W;
    localparam int          CFG_IDX_W        = jet_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W       = jet_pkg::CFG_DATA_W;

    localparam int          WATCHDOG_LIMIT   = 1_200_000;
    localparam int          TAIL_CYCLES      = 16;
    localparam int          RANDOM_PHASES    = 6;
    localparam int          POINTS_PER_PHASE = 100;
    localparam int          REPORT_LIMIT     = 10;
    localparam logic [63:0] DISC_RADIUS_SQ   = 64'd4 << (2 * FRAC_BITS);

    localparam logic signed [Z_W-1:0] Z_MAX   = 32'sh7fff_ffff;
    localparam logic signed [Z_W-1:0] Z_MIN   = 32'sh8000_0000;
    localparam logic signed [Z_W-1:0] Z_TWO   = 32'sd536870912;
    localparam logic signed [Z_W-1:0] Z_HALF  = 32'sd134217728;
    localparam logic signed [C_W-1:0] C_MAX   = 30'sh1fff_ffff;
    localparam logic signed [C_W-1:0] C_MIN   = 30'sh2000_0000;
    localparam logic signed [C_W-1:0] C_ZERO  = 30'sd0;

    typedef struct packed {
        logic signed [Z_W-1:0] start_re;
        logic signed [Z_W-1:0] start_im;
        logic [COUNT_W-1:0]    count;
    } escape_expect_t;

    class escape_count_board;
        logic signed [C_W-1:0] c_re;
        logic signed [C_W-1:0] c_im;
        logic [COUNT_W-1:0]    limit;
        escape_expect_t        pending_counts[$];
        int unsigned           failures;
        int unsigned           points_seen;
        int unsigned           counts_checked;
        int unsigned           outside_at_start;
        int unsigned           escaped;
        int unsigned           capped;

        function new();
            c_re  = jet_pkg::CONST_RE_RESET;
            c_im  = jet_pkg::CONST_IM_RESET;
            limit = jet_pkg::LIMIT_RESET;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                jet_pkg::CFG_CONST_RE: c_re = data[C_W-1:0];
                jet_pkg::CFG_CONST_IM: c_im = data[C_W-1:0];
                jet_pkg::CFG_LIMIT:    limit = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // z <- z*z + c in Q3.28 with exact 64-bit squares, floor shifts, 32-bit wrap
        function logic [COUNT_W-1:0] escape_steps(logic signed [Z_W-1:0] re0,
                                                  logic signed [Z_W-1:0] im0);
            longint      re;
            longint      im;
            longint      re_sq;
            longint      im_sq;
            longint      next_re;
            longint      next_im;
            logic [63:0] mag;
            int unsigned steps;
            re = re0;
            im = im0;
            steps = 0;
            forever
            begin
                re_sq = re * re;
                im_sq = im * im;
                mag = re_sq + im_sq;
                if (mag > DISC_RADIUS_SQ)
                    break;
                steps++;
                // a zero limit stops after the first step just like a limit of one
                if (steps >= limit)
                    break;
                next_re = ((re_sq - im_sq) >>> FRAC_BITS) + c_re;
                next_im = ((re * im) >>> (FRAC_BITS - 1)) + c_im;
                re = int'(next_re);
                im = int'(next_im);
            end
            return steps[COUNT_W-1:0];
        endfunction

        function void note_point(logic signed [Z_W-1:0] re, logic signed [Z_W-1:0] im);
            escape_expect_t e;
            e.start_re = re;
            e.start_im = im;
            e.count    = escape_steps(re, im);
            pending_counts.push_back(e);
            points_seen++;
            if (e.count == 0)
                outside_at_start++;
            else if (e.count == ((limit == 0) ? 1 : limit))
                capped++;
            else
                escaped++;
        endfunction

        function void check_count(logic [COUNT_W-1:0] got);
            escape_expect_t e;
            counts_checked++;
            if (pending_counts.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected escape count %0d with no request outstanding", got);
                return;
            end
            e = pending_counts.pop_front();
            if (got !== e.count)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("escape count mismatch for start (%0d, %0d): expected %0d, got %0d",
                             e.start_re, e.start_im, e.count, got);
            end
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [Z_W-1:0] start_re;
    logic signed [Z_W-1:0] start_im;
    logic                  out_valid;
    logic                  out_ready;
    logic [COUNT_W-1:0]    escape_count;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    escape_count_board board = new();
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_off_cycles;
    int settings_loaded;
    int stall_count;

    julia_escape_time_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_re     (start_re),
        .start_im     (start_im),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // result side: check what was taken at this edge, then pick next ready
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_count(escape_count);
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count = 0;
        else if (++stall_count >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved in %0d cycles", WATCHDOG_LIMIT);
            $display("julia_escape_time_unit test failed");
            $finish;
        end
    end

    function automatic int rand_span(int unsigned half);
        return int'($urandom_range(2 * half)) - int'(half);
    endfunction

    function automatic logic [C_W-1:0] pick_constant();
        if ($urandom_range(9) < 7)
            return C_W'(rand_span(1 << FRAC_BITS));
        return C_W'($urandom);
    endfunction

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    task automatic send_point(input logic signed [Z_W-1:0] re, input logic signed [Z_W-1:0] im);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_re <= re;
        start_im <= im;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_point(re, im);
    endtask

    // drop valid and let every outstanding count come back
    task automatic end_batch();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        board.set_register(idx, data);
    endtask

    task automatic load_constants(input logic [C_W-1:0] c_re, input logic [C_W-1:0] c_im,
                                  input logic [CFG_DATA_W-1:0] limit_word);
        write_register(jet_pkg::CFG_CONST_RE, CFG_DATA_W'(c_re));
        write_register(jet_pkg::CFG_CONST_IM, CFG_DATA_W'(c_im));
        write_register(jet_pkg::CFG_LIMIT, limit_word);
        cfg_write_en <= 1'b0;
        settings_loaded++;
    endtask

    initial
    begin
        logic signed [Z_W-1:0]  re;
        logic signed [Z_W-1:0]  im;
        logic [CFG_DATA_W-1:0]  limit_word;
        int                     pick;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        start_re     <= '0;
        start_im     <= '0;
        out_ready    <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= jet_pkg::CFG_CONST_RE;
        cfg_data     <= '0;
        hold_off_cycles = 0;
        settings_loaded = 1;
        stall_count = 0;
        set_idling(18, 81);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset constants: origin, points on and just past the radius-2 circle, extremes
        send_point(0, 0);
        send_point(Z_TWO, 0);
        send_point(Z_TWO + 1, 0);
        send_point(-Z_TWO, 0);
        send_point(0, Z_TWO);
        send_point(0, -Z_TWO - 1);
        send_point(Z_MAX, Z_MAX);
        send_point(Z_MIN, Z_MIN);
        send_point(Z_MIN, Z_MAX);
        send_point(Z_MAX, Z_MIN);
        send_point(2 * Z_HALF, -2 * Z_HALF);
        end_batch();

        // zero limit acts as one
        load_constants(C_ZERO, C_ZERO, 30'd0);
        send_point(0, 0);
        send_point(Z_MIN, 0);
        end_batch();

        // limit of one, with ignored upper bits set
        load_constants(C_ZERO, C_ZERO, 30'h3fff_0001);
        send_point(0, 0);
        send_point(2 * Z_HALF, 2 * Z_HALF);
        end_batch();

        load_constants(C_MIN, C_MAX, 30'd50);
        send_point(0, 0);
        send_point(Z_HALF, -Z_HALF);
        end_batch();

        load_constants(C_MAX, C_MIN, 30'd50);
        send_point(0, 0);
        end_batch();

        // c = -2 pins the orbit of the origin at exactly 2
        load_constants(C_MIN, C_ZERO, 30'd300);
        send_point(0, 0);
        end_batch();

        load_constants(C_ZERO, C_ZERO, 30'h0000_ffff);
        send_point(0, 0);
        send_point(Z_TWO, 0);
        send_point(3 * Z_HALF, 0);
        end_batch();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase / 2)
                0:       set_idling(18, 81);
                1:       set_idling(81, 18);
                default: set_idling(0, 0);
            endcase
            limit_word = CFG_DATA_W'($urandom);
            limit_word[COUNT_W-1:0] = (phase == 3) ? COUNT_W'($urandom_range(400, 200))
                                                   : COUNT_W'($urandom_range(48, 1));
            load_constants(pick_constant(), pick_constant(), limit_word);
            // long receiver stall so the core fills the output register and backs up
            if (phase == 4)
                hold_off_cycles = 500;
            repeat (POINTS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    re = rand_span(1 << (FRAC_BITS + 1));
                    im = rand_span(1 << (FRAC_BITS + 1));
                end
                else if (pick < 75)
                begin
                    re = rand_span(1 << (FRAC_BITS - 1));
                    im = rand_span(1 << (FRAC_BITS - 1));
                end
                else if (pick < 90)
                begin
                    re = $urandom;
                    im = $urandom;
                end
                else
                begin
                    case ($urandom_range(5))
                        0:       re = Z_MIN;
                        1:       re = Z_MAX;
                        2:       re = 0;
                        3:       re = Z_TWO;
                        4:       re = -Z_TWO;
                        default: re = Z_TWO + 1;
                    endcase
                    im = $urandom;
                end
                send_point(re, im);
            end
            end_batch();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ran %0d start points over %0d register settings, %0d counts checked",
                 board.points_seen, settings_loaded, board.counts_checked);
        $display("outcomes: %0d outside at start, %0d escaped, %0d held to the limit",
                 board.outside_at_start, board.escaped, board.capped);
        if (board.failures == 0 && board.pending() == 0)
            $display("julia_escape_time_unit test passed");
        else
        begin
            $display("%0d mismatches, %0d counts still outstanding",
                     board.failures, board.pending());
            $display("julia_escape_time_unit test failed");
        end
        $finish;
    end

endmodule
